@@ hw/rtl/rlkd_pkg.sv @@
// Shared constants, types and reset table for the resistor ladder key decoder.
package rlkd_pkg;

    localparam int NUM_BUTTONS   = 5;
    localparam int SAMPLE_BITS   = 10;
    localparam int KEY_BITS      = 3;
    localparam int SLOT_BITS     = $clog2(NUM_BUTTONS);
    localparam int TOL_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 6;
    localparam int CAL_LIMIT     = 1000;
    localparam int LIMIT_BITS    = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 1;

    localparam logic [KEY_BITS-1:0] NO_KEY             = KEY_BITS'(NUM_BUTTONS);
    localparam logic [2:0]          CAL_SLOT_RESET     = 3'd5;
    localparam logic [TOL_BITS-1:0] MATCH_TOL_RESET    = TOL_BITS'(8);
    localparam logic [TOL_BITS-1:0] CONFLICT_TOL_RESET = TOL_BITS'(10);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CAL_ENABLE   = 2'd0,
        REG_CAL_SLOT     = 2'd1,
        REG_MATCH_TOL    = 2'd2,
        REG_CONFLICT_TOL = 2'd3
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [NUM_BUTTONS-1:0] level_array_t;

    typedef struct packed {
        logic                cal_enable;
        logic [2:0]          cal_slot;
        logic [TOL_BITS-1:0] match_tol;
        logic [TOL_BITS-1:0] conflict_tol;
    } cfg_t;

    typedef struct packed {
        logic    mode;
        sample_t sample;
    } item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] sample_key;
        logic [KEY_BITS-1:0] held_button;
        logic                calibrated;
    } result_t;

    function automatic sample_t level_reset(input int idx);
        sample_t lv;
        case (idx)
            0:       lv = sample_t'(758);
            1:       lv = sample_t'(530);
            2:       lv = sample_t'(355);
            3:       lv = sample_t'(167);
            4:       lv = sample_t'(17);
            default: lv = '0;
        endcase
        return lv;
    endfunction

endpackage

@@ hw/rtl/rlkd_key_find.sv @@
// Window compare against every level, highest matching index wins.
module rlkd_key_find (
    input  rlkd_pkg::level_array_t          levels,
    input  rlkd_pkg::sample_t               sample,
    input  logic [rlkd_pkg::TOL_BITS-1:0]   tol,
    output logic [rlkd_pkg::KEY_BITS-1:0]   key
);
    import rlkd_pkg::*;

    always_comb
    begin
        logic [SAMPLE_BITS:0] s_ext;
        logic [SAMPLE_BITS:0] t_ext;
        logic [SAMPLE_BITS:0] l_ext;
        s_ext = {1'b0, sample};
        t_ext = (SAMPLE_BITS + 1)'(tol);
        key   = NO_KEY;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            l_ext = {1'b0, levels[i]};
            if ((s_ext <= l_ext + t_ext) && (s_ext + t_ext >= l_ext))
            begin
                key = KEY_BITS'(i);
            end
        end
    end

endmodule

@@ hw/rtl/rlkd_decode_core.sv @@
// Level table, key latches and per-item decode or calibration decision.
module rlkd_decode_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rlkd_pkg::item_t   item,
    input  rlkd_pkg::cfg_t    cfg,
    output rlkd_pkg::result_t result
);
    import rlkd_pkg::*;

    level_array_t        level_reg;
    logic [KEY_BITS-1:0] last_key_reg;
    logic [KEY_BITS-1:0] held_key_reg;
    logic [KEY_BITS-1:0] last_key_next;
    logic [KEY_BITS-1:0] held_key_next;

    logic [KEY_BITS-1:0] match_key;
    logic                conf_hit;
    logic [KEY_BITS-1:0] conf_key;
    logic                cal_path;
    logic                cal_write;
    logic [SLOT_BITS-1:0] slot_idx;

    rlkd_key_find u_match (
        .levels (level_reg),
        .sample (item.sample),
        .tol    (cfg.match_tol),
        .key    (match_key)
    );

    rlkd_key_find u_conflict (
        .levels (level_reg),
        .sample (item.sample),
        .tol    (cfg.conflict_tol),
        .key    (conf_key)
    );

    assign conf_hit = (conf_key != NO_KEY);
    assign slot_idx = cfg.cal_slot[SLOT_BITS-1:0];

    always_comb
    begin
        cal_path = !item.mode && cfg.cal_enable
                   && (LIMIT_BITS'(item.sample) < LIMIT_BITS'(CAL_LIMIT))
                   && ({1'b0, cfg.cal_slot} < 4'(NUM_BUTTONS));
        cal_write     = cal_path && (!conf_hit || (conf_key == cfg.cal_slot));
        last_key_next = last_key_reg;
        held_key_next = held_key_reg;
        result.sample_key  = NO_KEY;
        result.held_button = held_key_reg;
        result.calibrated  = cal_write;
        if (item.mode)
        begin
            held_key_next = NO_KEY;
        end
        else if (!cal_path)
        begin
            result.sample_key = match_key;
            if (match_key != last_key_reg)
            begin
                last_key_next      = match_key;
                held_key_next      = match_key;
                result.held_button = match_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                level_reg[i] <= level_reset(i);
            end
            last_key_reg <= NO_KEY;
            held_key_reg <= NO_KEY;
        end
        else if (step)
        begin
            if (cal_write)
            begin
                level_reg[slot_idx] <= item.sample;
            end
            last_key_reg <= last_key_next;
            held_key_reg <= held_key_next;
        end
    end

`ifndef SYNTHESIS
    a_cal_no_decode: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.calibrated |-> result.sample_key == NO_KEY)
        else $error("calibration sample produced a decoded key");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.mode |=> held_key_reg == NO_KEY)
        else $error("read did not clear held key");

    a_cal_written: assert property (@(posedge clk) disable iff (!rst_n)
        step && cal_write |=> level_reg[$past(slot_idx)] == $past(item.sample))
        else $error("calibrated level not stored");

    a_cal_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && cal_path |=> $stable(last_key_reg) && $stable(held_key_reg))
        else $error("calibration sample disturbed key latches");
`endif

endmodule

@@ hw/rtl/resistor_ladder_key_decoder_unit.sv @@
// Top level of the resistor ladder key decoder: handshake, registers, config.
//
// Input channel: in_valid/in_stall with fields mode and raw_sample. A transfer
// happens on a rising edge with in_valid high and in_stall low. mode 0 is an
// ADC sample, mode 1 reads and clears the held button.
// Output channel: out_valid/out_stall with sample_key, held_button, calibrated;
// exactly one result per input transfer, in order.
// Config: cfg_wen, cfg_index (0 cal_enable, 1 cal_slot, 2 match_tolerance,
// 3 conflict_tolerance), cfg_data; write only while idle.
// Pipeline: input register then result register; the decode is one
// pass of five parallel window compares feeding the key latches.
// Throughput: one item per cycle, back to back, while out_stall is low.
// Stall: while out_stall holds a waiting result, one more item is taken into
// the input register, then in_stall rises until the result is taken.
// Reset: levels 758, 530, 355, 167, 17; last and held keys no key; registers
// to their reset values; both pipeline stages empty.
module resistor_ladder_key_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [rlkd_pkg::SAMPLE_BITS-1:0]    raw_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rlkd_pkg::KEY_BITS-1:0]       sample_key,
    output logic [rlkd_pkg::KEY_BITS-1:0]       held_button,
    output logic                                calibrated,
    input  logic                                cfg_wen,
    input  logic [rlkd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rlkd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rlkd_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;
    result_t core_result;
    cfg_t    cfg_reg;
    logic    s1_adv;
    logic    in_take;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    rlkd_decode_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.mode   <= mode;
            s1_item_reg.sample <= raw_sample;
        end
        if (s1_adv)
        begin
            out_result_reg <= core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_enable   <= 1'b0;
            cfg_reg.cal_slot     <= CAL_SLOT_RESET;
            cfg_reg.match_tol    <= MATCH_TOL_RESET;
            cfg_reg.conflict_tol <= CONFLICT_TOL_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAL_ENABLE:   cfg_reg.cal_enable   <= cfg_data[0];
                REG_CAL_SLOT:     cfg_reg.cal_slot     <= cfg_data[2:0];
                REG_MATCH_TOL:    cfg_reg.match_tol    <= cfg_data[TOL_BITS-1:0];
                REG_CONFLICT_TOL: cfg_reg.conflict_tol <= cfg_data[TOL_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_key  = out_result_reg.sample_key;
    assign held_button = out_result_reg.held_button;
    assign calibrated  = out_result_reg.calibrated;

endmodule
